### sv/efhd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the event FIFO with delete by handle.
// No dependencies; imported by the top level and its checker.

package efhd_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int TIME_W     = 32;
   localparam int SOURCE_W   = 8;
   localparam int HANDLE_W   = 6;
   localparam int OCC_W      = 7;
   localparam int EVENT_W    = TIME_W + SOURCE_W;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_DELETE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_FULL       = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

endpackage

### sv/event_fifo_with_handle_delete.sv
`timescale 1ns / 1ps
// Event FIFO kept as a doubly linked list over slot memories, with delete by handle.
// Depends on efhd_pkg.
//
// Usage:
//   req channel: one command per item. req_tuser carries the command (enqueue,
//   dequeue, peek front, delete by handle), req_tdata the event time, source
//   and the slot handle for delete.
//   rsp channel: exactly one item per command: status in rsp_tuser, the
//   event fields, the handle and the occupancy after the command in rsp_tdata.
//   A result passes the command register, then the result register.
//   Throughput: one command per cycle unless rsp stalls. Every command reads the
//   slot memories once (data at the head, links at the head or at the handle)
//   and updates the list on leaving the command register; a write in flight is
//   forwarded to the following item's read, so back-to-back commands never wait.
//   The free slot is the lowest free one, found by a priority pick over the
//   per-slot used bits.
//   Reset empties the queue at once: all slots free, no clearing pass.
//   When the receiver stalls, the result register holds; one more command is
//   taken into the command register, then req_tready drops until rsp moves.

module event_fifo_with_handle_delete
   import efhd_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] event_time, [39:32] event_source, [45:40] slot_handle, [47:46] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] out_time, [39:32] out_source, [45:40] out_handle,
   // [52:46] occupancy, [55:53] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   // one bit above the handle so the bound itself fits in the compare
   localparam int XW     = ((SLOT_W > HANDLE_W) ? SLOT_W : HANDLE_W) + 1;

   // slot memories
   logic [EVENT_W-1:0] event_mem [CAPACITY];
   logic [SLOT_W-1:0]  next_mem  [CAPACITY];
   logic [SLOT_W-1:0]  prev_mem  [CAPACITY];

   // command register
   logic                in_valid_ff;
   cmd_type             cmd_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [SOURCE_W-1:0] source_ff;
   logic [HANDLE_W-1:0] handle_ff;

   // memory read data and write forwarding
   logic [EVENT_W-1:0] event_q_ff;
   logic [SLOT_W-1:0]  next_q_ff;
   logic [SLOT_W-1:0]  prev_q_ff;
   logic               fwd_event_hit_ff;
   logic [EVENT_W-1:0] fwd_event_ff;
   logic               fwd_next_hit_ff;
   logic [SLOT_W-1:0]  fwd_next_ff;
   logic               fwd_prev_hit_ff;
   logic [SLOT_W-1:0]  fwd_prev_ff;

   // list state
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // result register
   logic                out_valid_ff;
   status_type          status_ff, status_in;
   logic [TIME_W-1:0]   out_time_ff, out_time_in;
   logic [SOURCE_W-1:0] out_source_ff, out_source_in;
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;
   logic [OCC_W-1:0]    occ_ff;

   logic               req_accept;
   logic               exec_fire;
   logic [EVENT_W-1:0] rd_event;
   logic [SLOT_W-1:0]  rd_next;
   logic [SLOT_W-1:0]  rd_prev;
   logic [XW-1:0]      hx;
   logic [SLOT_W-1:0]  h_idx;
   logic               h_ok;
   logic [XW-1:0]      req_hx;
   logic [SLOT_W-1:0]  req_h_idx;
   cmd_type            req_cmd;
   logic [SLOT_W-1:0]  free_slot;

   logic               event_we, next_we, prev_we;
   logic [SLOT_W-1:0]  event_waddr, next_waddr, prev_waddr;
   logic [EVENT_W-1:0] event_wdata;
   logic [SLOT_W-1:0]  next_wdata, prev_wdata;
   logic [SLOT_W-1:0]  event_raddr, next_raddr, prev_raddr;

   assign exec_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || exec_fire);
   assign req_accept = req_tvalid && req_tready;

   assign rd_event = fwd_event_hit_ff ? fwd_event_ff : event_q_ff;
   assign rd_next  = fwd_next_hit_ff  ? fwd_next_ff  : next_q_ff;
   assign rd_prev  = fwd_prev_hit_ff  ? fwd_prev_ff  : prev_q_ff;

   assign hx    = XW'(handle_ff);
   assign h_idx = hx[SLOT_W-1:0];
   assign h_ok  = hx < XW'(CAPACITY);

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_hx    = XW'(req_tdata[TIME_W+SOURCE_W +: HANDLE_W]);
   assign req_h_idx = req_hx[SLOT_W-1:0];

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   // one command: list update, memory writes and result
   always_comb begin
      logic              empty;
      logic              full;
      logic              do_unlink;
      logic [SLOT_W-1:0] victim;
      empty         = (count_ff == '0);
      full          = (count_ff == CNT_W'(CAPACITY));
      do_unlink     = 1'b0;
      victim        = (cmd_ff == CMD_DELETE) ? h_idx : head_ff;
      used_in       = used_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      status_in     = ST_OK;
      out_time_in   = '0;
      out_source_in = '0;
      out_handle_in = '0;
      event_we      = 1'b0;
      event_waddr   = free_slot;
      event_wdata   = {source_ff, time_ff};
      next_we       = 1'b0;
      next_waddr    = tail_ff;
      next_wdata    = free_slot;
      prev_we       = 1'b0;
      prev_waddr    = free_slot;
      prev_wdata    = tail_ff;
      if (exec_fire) begin
         unique case (cmd_ff)
            CMD_ENQUEUE: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  event_we           = 1'b1;
                  used_in[free_slot] = 1'b1;
                  prev_we            = 1'b1;
                  if (!empty) begin
                     next_we = 1'b1;
                  end else begin
                     head_in = free_slot;
                  end
                  tail_in       = free_slot;
                  count_in      = count_ff + CNT_W'(1);
                  out_handle_in = HANDLE_W'(free_slot);
               end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  out_time_in   = rd_event[TIME_W-1:0];
                  out_source_in = rd_event[EVENT_W-1:TIME_W];
                  out_handle_in = HANDLE_W'(head_ff);
                  do_unlink     = (cmd_ff == CMD_DEQUEUE);
               end
            end
            CMD_DELETE: begin
               if (!(h_ok && used_ff[h_idx])) begin
                  status_in = ST_BAD_HANDLE;
               end else begin
                  do_unlink = 1'b1;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
         // head has no predecessor and tail no successor: stored links there are stale
         if (do_unlink) begin
            used_in[victim] = 1'b0;
            count_in        = count_ff - CNT_W'(1);
            if (victim != head_ff) begin
               next_we    = 1'b1;
               next_waddr = rd_prev;
               next_wdata = rd_next;
            end else begin
               head_in = rd_next;
            end
            if (victim != tail_ff) begin
               prev_we    = 1'b1;
               prev_waddr = rd_next;
               prev_wdata = rd_prev;
            end else begin
               tail_in = rd_prev;
            end
         end
      end
   end

   // read addresses for the next item follow the list as this command leaves it
   assign event_raddr = head_in;
   assign next_raddr  = (req_cmd == CMD_DELETE) ? req_h_idx : head_in;
   assign prev_raddr  = req_h_idx;

   always_ff @(posedge clock) begin
      if (event_we) begin
         event_mem[event_waddr] <= event_wdata;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (req_accept) begin
         event_q_ff       <= event_mem[event_raddr];
         next_q_ff        <= next_mem[next_raddr];
         prev_q_ff        <= prev_mem[prev_raddr];
         fwd_event_hit_ff <= event_we && (event_waddr == event_raddr);
         fwd_event_ff     <= event_wdata;
         fwd_next_hit_ff  <= next_we && (next_waddr == next_raddr);
         fwd_next_ff      <= next_wdata;
         fwd_prev_hit_ff  <= prev_we && (prev_waddr == prev_raddr);
         fwd_prev_ff      <= prev_wdata;
      end
   end

   // command register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (exec_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_cmd;
         time_ff   <= req_tdata[TIME_W-1:0];
         source_ff <= req_tdata[TIME_W +: SOURCE_W];
         handle_ff <= req_tdata[TIME_W+SOURCE_W +: HANDLE_W];
      end
   end

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         status_ff     <= status_in;
         out_time_ff   <= out_time_in;
         out_source_ff <= out_source_in;
         out_handle_ff <= out_handle_in;
         occ_ff        <= OCC_W'(count_in);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, occ_ff, out_handle_ff, out_source_ff, out_time_ff};

endmodule

### sv/efhd_check.sv
`timescale 1ns / 1ps
// Port-level checks for the event FIFO, bound to the top level.
// Depends on efhd_pkg and event_fifo_with_handle_delete.

module efhd_check
   import efhd_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 127) || (rsp_tdata[52:46] <= OCC_W'(CAPACITY)))
      else $error("occupancy above capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata[45:0] == '0)
      else $error("error result carries event fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> rsp_tdata[52:46] == '0)
      else $error("empty status with nonzero occupancy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |-> rsp_tdata[52:46] == OCC_W'(CAPACITY))
      else $error("full status below capacity");

endmodule

bind event_fifo_with_handle_delete efhd_check #(.CAPACITY(CAPACITY)) u_efhd_check (.*);
